/* rtl/obb_pkg.sv */
package obb_pkg;

	localparam int COORD_BITS_DEF = 24;
	localparam int AXIS_BITS_DEF  = 18;
	localparam int EPS_BITS       = 16;
	localparam logic [EPS_BITS-1:0] EPS_RESET = 16'd7;
	localparam logic [3:0] NO_AXIS = 4'd15;

	localparam int ADDR_W = 3;
	localparam logic REG_EPSILON = 1'b0;

	typedef enum logic [2:0] {
		S_IDLE,
		S_TVEC,
		S_RMAT,
		S_AXA,
		S_AXB,
		S_CROSS,
		S_OUT
	} state_t;

	typedef enum logic [1:0] {
		X_REFAX,
		X_AH,
		X_BH,
		X_T
	} xsel_t;

	typedef enum logic [2:0] {
		Y_BX,
		Y_DIFF,
		Y_AR,
		Y_R,
		Y_ONE
	} ysel_t;

	typedef enum logic [1:0] {
		SH_NONE,
		SH_ONE,
		SH_TWO,
		SH_THREE
	} shift_t;

	typedef enum logic [1:0] {
		FIN_NONE,
		FIN_T,
		FIN_R,
		FIN_CMP
	} fin_t;

	typedef struct packed {
		logic       load_ref;
		logic       load_box;
		logic       mac;
		xsel_t      xs;
		logic [3:0] xi;
		ysel_t      ys;
		logic [3:0] yi;
		logic       neg;
		shift_t     sh;
		logic       to_rad;
		logic       clr;
		logic [1:0] part;
		fin_t       fin;
		logic [3:0] fi;
	} cmd_t;

endpackage

/* rtl/obb_ctrl.sv */
module obb_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	input  logic          is_ref,
	output logic          s_tready,
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [3:0]    axis_out,
	output obb_pkg::cmd_t cmd,
	input  logic          sep
);
	import obb_pkg::*;

	function automatic logic [3:0] idx9(logic [1:0] a, logic [1:0] b);
		return 4'({a, 1'b0}) + 4'(a) + 4'(b);
	endfunction

	function automatic logic [1:0] nx(logic [1:0] a);
		return (a == 2'd2) ? 2'd0 : a + 2'd1;
	endfunction

	function automatic logic [2:0] last_op(state_t s);
		case (s)
			S_TVEC:  return 3'd3;
			S_RMAT:  return 3'd3;
			S_AXA:   return 3'd5;
			S_AXB:   return 3'd7;
			S_CROSS: return 3'd6;
			default: return 3'd0;
		endcase
	endfunction

	state_t     state_q, state_d;
	logic [1:0] gi_q, gi_d, gj_q, gj_d;
	logic [2:0] op_q, op_d;
	logic [1:0] part_q, part_d;
	logic       m_valid_q, m_valid_d;
	logic [3:0] hit_q, hit_d;
	logic [3:0] out_q, out_d;
	logic [1:0] i1, i2, j1, j2, ka;

	assign i1 = nx(gi_q);
	assign i2 = nx(i1);
	assign j1 = nx(gj_q);
	assign j2 = nx(j1);
	assign ka = 2'(op_q - 3'd2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			gi_q      <= '0;
			gj_q      <= '0;
			op_q      <= '0;
			part_q    <= '0;
			m_valid_q <= 1'b0;
			hit_q     <= NO_AXIS;
			out_q     <= NO_AXIS;
		end else begin
			state_q   <= state_d;
			gi_q      <= gi_d;
			gj_q      <= gj_d;
			op_q      <= op_d;
			part_q    <= part_d;
			m_valid_q <= m_valid_d;
			hit_q     <= hit_d;
			out_q     <= out_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		gi_d      = gi_q;
		gj_d      = gj_q;
		op_d      = op_q;
		part_d    = part_q;
		m_valid_d = m_valid_q;
		hit_d     = hit_q;
		out_d     = out_q;
		cmd       = '0;
		cmd.part  = part_q;
		s_tready  = (state_q == S_IDLE);

		// operand selection
		case (state_q)
			S_TVEC: begin
				cmd.xs  = X_REFAX;
				cmd.xi  = idx9(gi_q, op_q[1:0]);
				cmd.ys  = Y_DIFF;
				cmd.yi  = 4'(op_q[1:0]);
				cmd.clr = (op_q == 3'd0);
			end
			S_RMAT: begin
				cmd.xs  = X_REFAX;
				cmd.xi  = idx9(gi_q, op_q[1:0]);
				cmd.ys  = Y_BX;
				cmd.yi  = idx9(gj_q, op_q[1:0]);
				cmd.clr = (op_q == 3'd0);
			end
			S_AXA: begin
				case (op_q)
					3'd0: begin
						cmd.xs  = X_T;
						cmd.xi  = 4'(gi_q);
						cmd.ys  = Y_ONE;
						cmd.sh  = SH_ONE;
						cmd.clr = 1'b1;
					end
					3'd1: begin
						cmd.xs     = X_AH;
						cmd.xi     = 4'(gi_q);
						cmd.ys     = Y_ONE;
						cmd.sh     = SH_TWO;
						cmd.to_rad = 1'b1;
						cmd.clr    = 1'b1;
					end
					default: begin
						cmd.xs     = X_BH;
						cmd.xi     = 4'(ka);
						cmd.ys     = Y_AR;
						cmd.yi     = idx9(gi_q, ka);
						cmd.to_rad = 1'b1;
					end
				endcase
			end
			S_AXB: begin
				if (op_q == 3'd6) begin
					cmd.xs     = X_BH;
					cmd.xi     = 4'(gj_q);
					cmd.ys     = Y_ONE;
					cmd.sh     = SH_THREE;
					cmd.to_rad = 1'b1;
				end else if (!op_q[0]) begin
					cmd.xs     = X_AH;
					cmd.xi     = 4'(op_q[2:1]);
					cmd.ys     = Y_AR;
					cmd.yi     = idx9(op_q[2:1], gj_q);
					cmd.sh     = SH_ONE;
					cmd.to_rad = 1'b1;
					cmd.clr    = (op_q == 3'd0);
				end else begin
					cmd.xs  = X_T;
					cmd.xi  = 4'(op_q[2:1]);
					cmd.ys  = Y_R;
					cmd.yi  = idx9(op_q[2:1], gj_q);
					cmd.clr = (op_q == 3'd1);
				end
			end
			S_CROSS: begin
				cmd.to_rad = 1'b1;
				cmd.sh     = SH_ONE;
				cmd.ys     = Y_AR;
				case (op_q)
					3'd0: begin
						cmd.xs  = X_AH;
						cmd.xi  = 4'(i1);
						cmd.yi  = idx9(i2, gj_q);
						cmd.clr = 1'b1;
					end
					3'd1: begin
						cmd.xs = X_AH;
						cmd.xi = 4'(i2);
						cmd.yi = idx9(i1, gj_q);
					end
					3'd2: begin
						cmd.xs = X_BH;
						cmd.xi = 4'(j1);
						cmd.yi = idx9(gi_q, j2);
					end
					3'd3: begin
						cmd.xs = X_BH;
						cmd.xi = 4'(j2);
						cmd.yi = idx9(gi_q, j1);
					end
					3'd4: begin
						cmd.xs     = X_T;
						cmd.xi     = 4'(i2);
						cmd.ys     = Y_R;
						cmd.yi     = idx9(i1, gj_q);
						cmd.sh     = SH_NONE;
						cmd.to_rad = 1'b0;
						cmd.clr    = 1'b1;
					end
					default: begin
						cmd.xs     = X_T;
						cmd.xi     = 4'(i1);
						cmd.ys     = Y_R;
						cmd.yi     = idx9(i2, gj_q);
						cmd.sh     = SH_NONE;
						cmd.to_rad = 1'b0;
						cmd.neg    = 1'b1;
					end
				endcase
			end
			default: ;
		endcase

		if (m_valid_q && m_tready)
			m_valid_d = 1'b0;

		// sequencing
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					if (is_ref) begin
						cmd.load_ref = 1'b1;
					end else begin
						cmd.load_box = 1'b1;
						state_d = S_TVEC;
						gi_d    = '0;
						gj_d    = '0;
						op_d    = '0;
						part_d  = '0;
					end
				end
			end
			S_OUT: begin
				if (!m_valid_q || m_tready) begin
					m_valid_d = 1'b1;
					out_d     = hit_q;
					state_d   = S_IDLE;
				end
			end
			default: begin
				if (op_q != last_op(state_q)) begin
					cmd.mac = 1'b1;
					part_d  = part_q + 2'd1;
					if (part_q == 2'd3)
						op_d = op_q + 3'd1;
				end else begin
					op_d   = '0;
					part_d = '0;
					case (state_q)
						S_TVEC: begin
							cmd.fin = FIN_T;
							cmd.fi  = 4'(gi_q);
							if (gi_q == 2'd2) begin
								state_d = S_RMAT;
								gi_d    = '0;
								gj_d    = '0;
							end else begin
								gi_d = gi_q + 2'd1;
							end
						end
						S_RMAT: begin
							cmd.fin = FIN_R;
							cmd.fi  = idx9(gi_q, gj_q);
							if (gj_q == 2'd2) begin
								gj_d = '0;
								if (gi_q == 2'd2) begin
									state_d = S_AXA;
									gi_d    = '0;
								end else begin
									gi_d = gi_q + 2'd1;
								end
							end else begin
								gj_d = gj_q + 2'd1;
							end
						end
						S_AXA: begin
							cmd.fin = FIN_CMP;
							if (sep) begin
								hit_d   = 4'(gi_q);
								state_d = S_OUT;
							end else if (gi_q == 2'd2) begin
								state_d = S_AXB;
								gi_d    = '0;
								gj_d    = '0;
							end else begin
								gi_d = gi_q + 2'd1;
							end
						end
						S_AXB: begin
							cmd.fin = FIN_CMP;
							if (sep) begin
								hit_d   = 4'd3 + 4'(gj_q);
								state_d = S_OUT;
							end else if (gj_q == 2'd2) begin
								state_d = S_CROSS;
								gi_d    = '0;
								gj_d    = '0;
							end else begin
								gj_d = gj_q + 2'd1;
							end
						end
						S_CROSS: begin
							cmd.fin = FIN_CMP;
							if (sep) begin
								hit_d   = 4'd6 + idx9(gi_q, gj_q);
								state_d = S_OUT;
							end else if (gj_q == 2'd2) begin
								gj_d = '0;
								if (gi_q == 2'd2) begin
									hit_d   = NO_AXIS;
									state_d = S_OUT;
								end else begin
									gi_d = gi_q + 2'd1;
								end
							end else begin
								gj_d = gj_q + 2'd1;
							end
						end
						default: ;
					endcase
				end
			end
		endcase
	end

	assign m_tvalid = m_valid_q;
	assign axis_out = out_q;

endmodule

/* rtl/obb_dp.sv */
module obb_dp #(
	parameter int COORD_BITS = obb_pkg::COORD_BITS_DEF,
	parameter int AXIS_BITS  = obb_pkg::AXIS_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  obb_pkg::cmd_t                cmd,
	input  logic [obb_pkg::EPS_BITS-1:0] eps,
	input  logic [COORD_BITS-1:0]        center_x,
	input  logic [COORD_BITS-1:0]        center_y,
	input  logic [COORD_BITS-1:0]        center_z,
	input  logic [3*AXIS_BITS-1:0]       axis_zero,
	input  logic [3*AXIS_BITS-1:0]       axis_one,
	input  logic [3*AXIS_BITS-1:0]       axis_two,
	input  logic [COORD_BITS-2:0]        half_x,
	input  logic [COORD_BITS-2:0]        half_y,
	input  logic [COORD_BITS-2:0]        half_z,
	output logic                         sep
);
	import obb_pkg::*;

	localparam int CB  = COORD_BITS;
	localparam int AB  = AXIS_BITS;
	localparam int HB  = CB - 1;
	localparam int FA  = AB - 2;
	localparam int DW  = CB + 1;
	localparam int TW  = CB + AB + 3;
	localparam int RW  = 2 * AB + 2;
	localparam int ARW = ((2 * AB > AB + 14) ? 2 * AB : AB + 14) + 1;
	localparam int MXW = TW;
	localparam int MYW0 = (ARW > RW) ? ARW : RW;
	localparam int MYW = (MYW0 > DW) ? MYW0 : DW;
	localparam int XH  = (MXW + 1) / 2;
	localparam int YH  = (MYW + 1) / 2;
	localparam int AC0 = TW + RW;
	localparam int AC1 = HB + ARW + FA + 2;
	localparam int AC2 = HB + 3 * FA + 1;
	localparam int AC3 = (AC0 > AC1) ? AC0 : AC1;
	localparam int ACW = ((AC3 > AC2) ? AC3 : AC2) + 4;
	localparam int OFW = $clog2(XH + YH + 3 * FA + 1);

	logic signed [CB-1:0] ref_c [3];
	logic signed [AB-1:0] ref_ax [9];
	logic        [HB-1:0] ref_h [3];
	logic signed [CB-1:0] b_c [3];
	logic signed [AB-1:0] b_ax [9];
	logic        [HB-1:0] b_h [3];
	logic signed [TW-1:0] t_q [3];
	logic signed [RW-1:0] r_q [9];
	logic       [ARW-1:0] ar_q [9];
	logic       [ACW-1:0] acc_d_q, acc_r_q;

	logic signed [CB-1:0]  in_c [3];
	logic [3*AB-1:0]       in_ax [3];
	logic [HB-1:0]         in_h [3];

	logic signed [MXW:0]   xv;
	logic signed [MYW:0]   yv;
	logic [MXW-1:0]        x_mag;
	logic [MYW-1:0]        y_mag;
	logic                  x_neg, y_neg;
	logic [2*XH-1:0]       x_ext;
	logic [2*YH-1:0]       y_ext;
	logic [XH-1:0]         xp;
	logic [YH-1:0]         yp;
	logic [XH+YH-1:0]      pp;
	logic [OFW-1:0]        off, sh_amt;
	logic [ACW-1:0]        term, sterm, base, sum, dist_abs;
	logic [ARW-1:0]        eps_sh;

	assign in_c[0]  = center_x;
	assign in_c[1]  = center_y;
	assign in_c[2]  = center_z;
	assign in_ax[0] = axis_zero;
	assign in_ax[1] = axis_one;
	assign in_ax[2] = axis_two;
	assign in_h[0]  = half_x;
	assign in_h[1]  = half_y;
	assign in_h[2]  = half_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++) begin
				ref_c[k] <= '0;
				ref_h[k] <= '0;
			end
			for (int k = 0; k < 9; k++)
				ref_ax[k] <= '0;
		end else if (cmd.load_ref) begin
			for (int k = 0; k < 3; k++) begin
				ref_c[k] <= in_c[k];
				ref_h[k] <= in_h[k];
				for (int j = 0; j < 3; j++)
					ref_ax[3*k+j] <= in_ax[k][j*AB +: AB];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_box) begin
			for (int k = 0; k < 3; k++) begin
				b_c[k] <= in_c[k];
				b_h[k] <= in_h[k];
				for (int j = 0; j < 3; j++)
					b_ax[3*k+j] <= in_ax[k][j*AB +: AB];
			end
		end
	end

	always_comb begin
		case (cmd.xs)
			X_REFAX: xv = (MXW+1)'(ref_ax[cmd.xi]);
			X_AH:    xv = signed'((MXW+1)'(ref_h[cmd.xi[1:0]]));
			X_BH:    xv = signed'((MXW+1)'(b_h[cmd.xi[1:0]]));
			X_T:     xv = (MXW+1)'(t_q[cmd.xi[1:0]]);
			default: xv = '0;
		endcase
		x_neg = xv[MXW];
		x_mag = x_neg ? MXW'(-xv) : MXW'(xv);

		case (cmd.ys)
			Y_BX:    yv = (MYW+1)'(b_ax[cmd.yi]);
			Y_DIFF:  yv = (MYW+1)'(b_c[cmd.yi[1:0]]) - (MYW+1)'(ref_c[cmd.yi[1:0]]);
			Y_AR:    yv = signed'((MYW+1)'(ar_q[cmd.yi]));
			Y_R:     yv = (MYW+1)'(r_q[cmd.yi]);
			Y_ONE:   yv = (MYW+1)'(1);
			default: yv = '0;
		endcase
		y_neg = yv[MYW];
		y_mag = y_neg ? MYW'(-yv) : MYW'(yv);
	end

	assign x_ext = (2*XH)'(x_mag);
	assign y_ext = (2*YH)'(y_mag);
	assign xp    = cmd.part[0] ? x_ext[2*XH-1:XH] : x_ext[XH-1:0];
	assign yp    = cmd.part[1] ? y_ext[2*YH-1:YH] : y_ext[YH-1:0];
	assign pp    = (XH+YH)'(xp) * (XH+YH)'(yp);

	always_comb begin
		case (cmd.sh)
			SH_NONE:  sh_amt = '0;
			SH_ONE:   sh_amt = OFW'(FA);
			SH_TWO:   sh_amt = OFW'(2 * FA);
			SH_THREE: sh_amt = OFW'(3 * FA);
			default:  sh_amt = '0;
		endcase
	end

	assign off   = (cmd.part[0] ? OFW'(XH) : OFW'(0)) + (cmd.part[1] ? OFW'(YH) : OFW'(0))
		+ sh_amt;
	assign term  = ACW'(pp) << off;
	assign sterm = (x_neg ^ y_neg ^ cmd.neg) ? -term : term;
	assign base  = (cmd.clr && cmd.part == 2'd0) ? '0 : (cmd.to_rad ? acc_r_q : acc_d_q);
	assign sum   = base + sterm;

	assign dist_abs = acc_d_q[ACW-1] ? -acc_d_q : acc_d_q;
	assign sep      = dist_abs > acc_r_q;
	assign eps_sh   = ARW'(eps) << FA;

	always_ff @(posedge clk) begin
		if (cmd.mac) begin
			if (cmd.to_rad)
				acc_r_q <= sum;
			else
				acc_d_q <= sum;
		end
		case (cmd.fin)
			FIN_T: t_q[cmd.fi[1:0]] <= acc_d_q[TW-1:0];
			FIN_R: begin
				r_q[cmd.fi]  <= acc_d_q[RW-1:0];
				ar_q[cmd.fi] <= dist_abs[ARW-1:0] + eps_sh;
			end
			default: ;
		endcase
	end

endmodule

/* rtl/oriented_box_overlap_test.sv */
// Oriented box overlap test, fifteen-axis separating-axis test.
// Input stream s_*: one box per item. tuser = is_reference. A reference box
// is stored as it is accepted and gives no result. Any other box is tested
// against the stored reference and gives one result item on m_*.
// Output tdata: overlap in bit 0, separating axis (0..14, 15 = none) in 4:1.
// Epsilon register at APB byte address 0, reset 7.
// A test item runs through one shared multiply-accumulate unit
// that does one partial product (about 23x19 at default widths) per cycle,
// four per term. Rotation and translation setup takes 36 terms and the
// fifteen axes take 90 more, plus one step per group for store or compare.
// When the result is registered the controller returns to idle and can take
// the next box; a test stops at the first separating axis.
// s_tready is high while the controller is idle; a finished result waits in
// an output register, so the next box is taken even while m_tready is low.
// A further result then holds until the pending one is taken.
// Reset clears the reference box to zeros and epsilon to 7.
module oriented_box_overlap_test #(
	parameter int COORD_BITS = obb_pkg::COORD_BITS_DEF,
	parameter int AXIS_BITS  = obb_pkg::AXIS_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	// center_x, center_y, center_z, axis_zero, axis_one, axis_two,
	// half_x, half_y, half_z, zero pad
	input  logic [((6*COORD_BITS-3+9*AXIS_BITS+7)/8)*8-1:0] s_tdata,
	// is_reference
	input  logic                       s_tuser,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// overlap, separating_axis[3:0], zero pad
	output logic [7:0]                 m_tdata,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [obb_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);
	import obb_pkg::*;

	localparam int CB = COORD_BITS;
	localparam int AB = AXIS_BITS;
	localparam int HB = CB - 1;
	localparam int OFF_AX = 3 * CB;
	localparam int OFF_H  = OFF_AX + 9 * AB;

	logic [EPS_BITS-1:0] eps_q;
	logic                wr;
	cmd_t                cmd;
	logic                sep;
	logic [3:0]          axis_out;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite && (paddr[ADDR_W-1:2] == REG_EPSILON);
	assign prdata = (paddr[ADDR_W-1:2] == REG_EPSILON) ? 32'(eps_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			eps_q <= EPS_RESET;
		else if (wr)
			eps_q <= pwdata[EPS_BITS-1:0];
	end

	obb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.is_ref   (s_tuser),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.axis_out (axis_out),
		.cmd      (cmd),
		.sep      (sep)
	);

	obb_dp #(
		.COORD_BITS (COORD_BITS),
		.AXIS_BITS  (AXIS_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.eps       (eps_q),
		.center_x  (s_tdata[0 +: CB]),
		.center_y  (s_tdata[CB +: CB]),
		.center_z  (s_tdata[2*CB +: CB]),
		.axis_zero (s_tdata[OFF_AX +: 3*AB]),
		.axis_one  (s_tdata[OFF_AX+3*AB +: 3*AB]),
		.axis_two  (s_tdata[OFF_AX+6*AB +: 3*AB]),
		.half_x    (s_tdata[OFF_H +: HB]),
		.half_y    (s_tdata[OFF_H+HB +: HB]),
		.half_z    (s_tdata[OFF_H+2*HB +: HB]),
		.sep       (sep)
	);

	assign m_tdata = {3'b000, axis_out, (axis_out == NO_AXIS)};

`ifndef SYNTHESIS
	a_test_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && !s_tuser) |=> !s_tready)
		else $error("test item accepted without going busy");

	a_ref_quick: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tuser) |=> s_tready)
		else $error("reference item stalled the input");

	a_result_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[0] == (m_tdata[4:1] == NO_AXIS)) && (m_tdata[7:5] == 3'b000))
		else $error("overlap flag disagrees with axis code");
`endif

endmodule

/* tb/sv/oriented_box_overlap_checker.sv */
`timescale 1ns / 100ps

module oriented_box_overlap_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	input  logic                       s_tready,
	// center_x, center_y, center_z, axis_zero, axis_one, axis_two,
	// half_x, half_y, half_z, zero pad
	input  logic [303:0]               s_tdata,
	// is_reference
	input  logic                       s_tuser,
	input  logic                       m_tvalid,
	input  logic                       m_tready,
	// overlap, separating_axis[3:0], zero pad
	input  logic [7:0]                 m_tdata,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [obb_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	input  logic [31:0]                prdata,
	input  logic                       pready,
	output int                         fails,
	output int                         pending,
	output int                         results,
	output int                         overlaps
);
	import obb_pkg::*;

	typedef logic signed [127:0] w_t;

	logic signed [23:0] ref_c[3];
	logic signed [17:0] ref_ax[9];
	logic [22:0]        ref_h[3];
	logic [15:0]        eps;
	logic [4:0]         verdicts[$];

	function automatic w_t wabs(input w_t v);
		return (v < 0) ? -v : v;
	endfunction

	// returns {separating axis, overlap}
	function automatic logic [4:0] sat_verdict(input logic [303:0] d);
		longint bc[3], bh[3], bx[9], t[3], r[3][3], ar[3][3];
		w_t rad, dsum;
		int hit, i1, i2, j1, j2;
		hit = NO_AXIS;
		for (int k = 0; k < 3; k++) begin
			bc[k] = longint'($signed(d[24*k +: 24]));
			bh[k] = longint'(d[234+23*k +: 23]);
			for (int j = 0; j < 3; j++)
				bx[3*k+j] = longint'($signed(d[72+54*k+18*j +: 18]));
		end
		for (int i = 0; i < 3; i++) begin
			t[i] = 0;
			for (int k = 0; k < 3; k++)
				t[i] += (bc[k] - longint'(ref_c[k])) * longint'(ref_ax[3*i+k]);
			for (int j = 0; j < 3; j++) begin
				r[i][j] = 0;
				for (int k = 0; k < 3; k++)
					r[i][j] += longint'(ref_ax[3*i+k]) * bx[3*j+k];
				ar[i][j] = ((r[i][j] < 0) ? -r[i][j] : r[i][j]) + (longint'(eps) << 16);
			end
		end
		for (int i = 0; i < 3 && hit == NO_AXIS; i++) begin
			rad = w_t'(longint'(ref_h[i])) << 32;
			for (int j = 0; j < 3; j++)
				rad += w_t'(bh[j]) * w_t'(ar[i][j]);
			if ((wabs(w_t'(t[i])) << 16) > rad) hit = i;
		end
		for (int j = 0; j < 3 && hit == NO_AXIS; j++) begin
			rad = 0;
			dsum = 0;
			for (int i = 0; i < 3; i++) begin
				rad += w_t'(longint'(ref_h[i])) * w_t'(ar[i][j]);
				dsum += w_t'(t[i]) * w_t'(r[i][j]);
			end
			rad = (rad << 16) + (w_t'(bh[j]) << 48);
			if (wabs(dsum) > rad) hit = 3 + j;
		end
		for (int i = 0; i < 3 && hit == NO_AXIS; i++) begin
			i1 = (i + 1) % 3;
			i2 = (i + 2) % 3;
			for (int j = 0; j < 3 && hit == NO_AXIS; j++) begin
				j1 = (j + 1) % 3;
				j2 = (j + 2) % 3;
				rad = w_t'(longint'(ref_h[i1])) * w_t'(ar[i2][j])
					+ w_t'(longint'(ref_h[i2])) * w_t'(ar[i1][j])
					+ w_t'(bh[j1]) * w_t'(ar[i][j2])
					+ w_t'(bh[j2]) * w_t'(ar[i][j1]);
				rad = rad << 16;
				dsum = w_t'(t[i2]) * w_t'(r[i1][j]) - w_t'(t[i1]) * w_t'(r[i2][j]);
				if (wabs(dsum) > rad) hit = 6 + 3*i + j;
			end
		end
		return {hit[3:0], hit == NO_AXIS};
	endfunction

	task automatic report(input string what, input int got, input int want);
		$display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
		fails++;
	endtask

	assign pending = verdicts.size();

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++) begin
				ref_c[k] = '0;
				ref_h[k] = '0;
			end
			for (int k = 0; k < 9; k++) ref_ax[k] = '0;
			eps = EPS_RESET;
			verdicts.delete();
			fails = 0;
			results = 0;
			overlaps = 0;
		end else begin
			logic [4:0] want;
			if (m_tvalid && m_tready) begin
				results++;
				if (verdicts.size() == 0) begin
					report("unexpected result item", m_tdata, -1);
				end else begin
					want = verdicts.pop_front();
					if (m_tdata[0] != want[0]) report("overlap", m_tdata[0], want[0]);
					if (m_tdata[4:1] != want[4:1])
						report("separating_axis", m_tdata[4:1], want[4:1]);
					if (m_tdata[0]) overlaps++;
				end
			end
			if (s_tvalid && s_tready) begin
				if (s_tuser) begin
					for (int k = 0; k < 3; k++) begin
						ref_c[k] = s_tdata[24*k +: 24];
						ref_h[k] = s_tdata[234+23*k +: 23];
						for (int j = 0; j < 3; j++)
							ref_ax[3*k+j] = s_tdata[72+54*k+18*j +: 18];
					end
				end else begin
					verdicts.push_back(sat_verdict(s_tdata));
				end
			end
			if (psel && penable && pready && (paddr >> 2) == ADDR_W'(REG_EPSILON)) begin
				if (pwrite) eps = pwdata[15:0];
				else if (prdata[15:0] != eps) report("epsilon readback", prdata[15:0], eps);
			end
		end
	end

endmodule

/* tb/sv/tb_oriented_box_overlap_test.sv */
`timescale 1ns / 100ps

module tb_oriented_box_overlap_test;
	import obb_pkg::*;

	localparam int ONE = 65536;
	localparam int DRAIN = 600;

	logic clk, arst_n;
	logic s_tvalid, s_tready, s_tuser;
	logic [303:0] s_tdata;
	logic m_tvalid, m_tready;
	logic [7:0] m_tdata;
	logic psel, penable, pwrite, pready;
	logic [ADDR_W-1:0] paddr;
	logic [31:0] pwdata, prdata;
	int fails, pending, results, overlaps;
	int send_idle, recv_idle, boxes;

	oriented_box_overlap_test dut (.*);
	oriented_box_overlap_checker chk (.*);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	initial begin
		#20ms;
		$display("timeout");
		$display("Verification failed");
		$finish;
	end

	always @(posedge clk) m_tready <= ($urandom_range(99) >= recv_idle);

	function automatic logic [53:0] axis3(input int x, input int y, input int z);
		return {18'(z), 18'(y), 18'(x)};
	endfunction

	function automatic logic [303:0] pack_box(input int cx, input int cy, input int cz,
			input logic [53:0] a0, input logic [53:0] a1, input logic [53:0] a2,
			input int hx, input int hy, input int hz);
		return {1'b0, 23'(hz), 23'(hy), 23'(hx), a2, a1, a0, 24'(cz), 24'(cy), 24'(cx)};
	endfunction

	function automatic logic [303:0] noise_box();
		logic [303:0] v;
		for (int k = 0; k < 9; k++) v[32*k +: 32] = $urandom;
		v[303:288] = 16'($urandom);
		v[303] = 1'b0;
		return v;
	endfunction

	// near-unit axes: signed permutation with a little jitter
	function automatic logic [303:0] shaped_box();
		int c[3], sp, jit;
		logic [53:0] ax[3];
		sp = $urandom_range(2);
		jit = ($urandom_range(3) == 0) ? 0 : $urandom_range(6000);
		for (int k = 0; k < 3; k++) begin
			for (int j = 0; j < 3; j++)
				c[j] = $urandom_range(2*jit) - jit;
			c[(k + sp) % 3] = $urandom_range(1) ? ONE - c[0] / 8 : -ONE + c[1] / 8;
			ax[k] = axis3(c[0], c[1], c[2]);
		end
		return pack_box($urandom_range(4096) - 2048, $urandom_range(4096) - 2048,
			$urandom_range(4096) - 2048, ax[0], ax[1], ax[2],
			$urandom_range(1100), $urandom_range(1100), $urandom_range(1100));
	endfunction

	task automatic send(input logic is_ref, input logic [303:0] d);
		if ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= is_ref;
		s_tdata <= d;
		do @(posedge clk); while (!s_tready);
		boxes++;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic apb(input logic wr, input logic [ADDR_W-1:0] a, input logic [31:0] v);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= a;
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_epsilon(input logic [15:0] v);
		apb(1'b1, ADDR_W'(REG_EPSILON) << 2, {16'hffff, v});
		apb(1'b0, ADDR_W'(REG_EPSILON) << 2, '0);
	endtask

	task automatic random_phase(input int n);
		int roll;
		repeat (n) begin
			roll = $urandom_range(99);
			if (roll < 20) send(1'b1, shaped_box());
			else if (roll < 80) send(1'b0, shaped_box());
			else if (roll < 90) send(1'b1, noise_box());
			else send(1'b0, noise_box());
		end
	endtask

	initial begin
		logic [53:0] ex, ey, ez, amax, amin;
		ex = axis3(ONE, 0, 0);
		ey = axis3(0, ONE, 0);
		ez = axis3(0, 0, ONE);
		amax = axis3(131071, 131071, 131071);
		amin = axis3(-131072, -131072, -131072);
		boxes = 0;
		send_idle = 0;
		recv_idle = 0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tuser = 1'b0;
		s_tdata = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// no reference stored yet
		send(1'b0, pack_box(8388607, 8388607, 8388607, amax, amax, amax,
			8388607, 8388607, 8388607));
		send(1'b0, pack_box(-8388608, -8388608, -8388608, amin, amin, amin, 0, 0, 0));
		send(1'b0, pack_box(0, 0, 0, ex, ey, ez, 0, 0, 0));
		drain();
		set_epsilon(16'd0);
		apb(1'b1, 3'd4, 32'h1234);
		send(1'b1, pack_box(0, 0, 0, ex, ey, ez, 256, 256, 256));
		send(1'b0, pack_box(512, 0, 0, ex, ey, ez, 256, 256, 256));
		send(1'b0, pack_box(513, 0, 0, ex, ey, ez, 256, 256, 256));
		send(1'b0, pack_box(0, -513, 0, ex, ey, ez, 256, 256, 256));
		send(1'b0, pack_box(0, 0, 600, ex, ey, ez, 256, 256, 256));
		send(1'b0, pack_box(0, 0, 0, ex, ey, ez, 256, 256, 256));
		send(1'b0, pack_box(700, 700, 0, axis3(46341, 46341, 0), axis3(-46341, 46341, 0),
			ez, 10, 10, 10));
		send(1'b0, pack_box(300, 300, 300, '0, '0, '0, 0, 0, 0));
		send(1'b1, pack_box(-8388608, 8388607, -8388608, amin, amax, amin,
			8388607, 0, 8388607));
		send(1'b0, pack_box(8388607, -8388608, 8388607, amax, amin, amax,
			8388607, 8388607, 0));
		send(1'b0, pack_box(0, 0, 0, amin, amin, amax, 0, 8388607, 8388607));
		drain();

		set_epsilon(16'hffff);
		send_idle = 34;
		recv_idle = 84;
		random_phase(410);
		drain();
		set_epsilon(16'($urandom_range(300)));
		send_idle = 84;
		recv_idle = 34;
		random_phase(410);
		drain();
		set_epsilon(EPS_RESET);
		send_idle = 0;
		recv_idle = 0;
		random_phase(410);
		drain();

		$display("%0d boxes sent under four epsilon settings and three stall patterns", boxes);
		$display("%0d test results checked, %0d overlapping, %0d mismatches",
			results, overlaps, fails);
		if (fails == 0) $display("Verification passed");
		else $display("Verification failed");
		$finish;
	end

endmodule

/* oriented_box_overlap_test.f */
rtl/obb_pkg.sv
rtl/obb_ctrl.sv
rtl/obb_dp.sv
rtl/oriented_box_overlap_test.sv
tb/sv/oriented_box_overlap_checker.sv
tb/sv/tb_oriented_box_overlap_test.sv
